### rtl/core/chained_hash_table_engine_core_defines.svh
// assertion macros shared by the hash table engine
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHTE_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CHTE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/chte_pkg.sv
package chte_pkg;

  localparam int NUM_BUCKETS_DEF      = 10;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_ROW,
    S_INS,
    S_READ,
    S_CMP,
    S_FINISH
  } state_e;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic key_we;
    logic key_re;
    logic valid_set;
    logic valid_clr;
  } store_ctrl_t;

endpackage

### rtl/core/chte_mod.sv
// key modulo bucket count by reciprocal multiplication, one multiply then a short subtract
module chte_mod #(
  parameter int NUM_BUCKETS = chte_pkg::NUM_BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [chte_pkg::KEY_W-1:0]     key_i,
  output logic                           done_o,
  output logic [$clog2(NUM_BUCKETS)-1:0] rem_o
);

  localparam int KW = chte_pkg::KEY_W;
  localparam int RW = $clog2(NUM_BUCKETS);
  localparam int SH = KW + RW;
  localparam int MW = KW + 1;
  localparam int PW = KW + MW;
  // one above 2^SH / NUM_BUCKETS, exact quotient for every key of KW bits
  localparam longint unsigned RECIP = ((64'd1 << SH) / NUM_BUCKETS) + 64'd1;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
  localparam logic [RW-1:0] NB_LO_C = RW'(NUM_BUCKETS);

  logic [RW-1:0] quo_w;
  logic [RW-1:0] key_lo_q, quo_lo_q;
  logic [RW-1:0] rem_q, rem_d;
  logic          sub_q, done_q;

  // only the low quotient bits matter, the remainder fits below the modulus
  assign quo_w = RW'((PW'(key_i) * PW'(RECIP_C)) >> SH);
  assign rem_d = key_lo_q - RW'(quo_lo_q * NB_LO_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      sub_q  <= start_i;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_lo_q <= key_i[RW-1:0];
      quo_lo_q <= quo_w;
    end
    if (sub_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/chte_store.sv
// slot key memory plus per-bucket valid rows
module chte_store #(
  parameter int NUM_BUCKETS      = chte_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = chte_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  chte_pkg::store_ctrl_t                          ctrl_i,
  input  logic [$clog2(NUM_BUCKETS*SLOTS_PER_BUCKET)-1:0] addr_i,
  input  logic [$clog2(NUM_BUCKETS)-1:0]                 bkt_i,
  input  logic [((SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1)-1:0] slot_i,
  input  logic [chte_pkg::KEY_W-1:0]                     wkey_i,
  output logic [chte_pkg::KEY_W-1:0]                     rkey_o,
  output logic [SLOTS_PER_BUCKET-1:0]                    row_o
);

  localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;

  logic [chte_pkg::KEY_W-1:0]  key_mem [TOTAL];
  logic [chte_pkg::KEY_W-1:0]  rkey_q;
  logic [SLOTS_PER_BUCKET-1:0] valid_q [NUM_BUCKETS];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_we) begin
      key_mem[addr_i] <= wkey_i;
    end
    if (ctrl_i.key_re) begin
      rkey_q <= key_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else begin
      if (ctrl_i.valid_set) begin
        valid_q[bkt_i][slot_i] <= 1'b1;
      end
      if (ctrl_i.valid_clr) begin
        valid_q[bkt_i][slot_i] <= 1'b0;
      end
    end
  end

  assign rkey_o = rkey_q;
  assign row_o  = valid_q[bkt_i];

endmodule

### rtl/core/chained_hash_table_engine_core.sv
// sequence: modulo unit, then the bucket row lookup; insert then writes the lowest free
//   slot, search and delete read and compare slot by slot up to a match or the last slot
// throughput: one item at a time; the reciprocal modulo unit and the one key memory
//   read port (read then compare per slot) set the pace
// reset: asynchronous active low, clears every valid bit at once; key memory is not cleared
`include "chained_hash_table_engine_core_defines.svh"

module chained_hash_table_engine_core #(
  parameter int NUM_BUCKETS      = chte_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = chte_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [chte_pkg::CMD_W-1:0]    cmd_i,
  input  logic [chte_pkg::KEY_W-1:0]    key_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [chte_pkg::STATUS_W-1:0] status_o,
  output logic [chte_pkg::BUCKET_W-1:0] bucket_o
);

  localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = $clog2(TOTAL);
  localparam int BKW   = $clog2(NUM_BUCKETS);
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  // sequencer state
  chte_pkg::state_e      state_q, state_d;
  chte_pkg::store_ctrl_t st_ctrl;

  // item held for the whole operation
  logic [chte_pkg::CMD_W-1:0] cmd_q;
  logic [chte_pkg::KEY_W-1:0] key_q;

  // bucket row bookkeeping
  logic [BKW-1:0]              bkt_w;
  logic [AW-1:0]               base_q;
  logic [AW-1:0]               addr_w;
  logic [SW-1:0]               slot_q;
  logic [SW-1:0]               free_slot;
  logic                        any_free;
  logic                        has_free_q;
  logic [SLOTS_PER_BUCKET-1:0] row_w;
  logic [chte_pkg::KEY_W-1:0]  rkey_w;
  logic                        hit_w;
  logic                        last_w;
  logic                        mod_done;
  chte_pkg::status_e           status_q;

  // output register, frees the input side while a result waits
  logic                        out_valid_q;
  chte_pkg::status_e           out_status_q;
  logic [chte_pkg::BUCKET_W-1:0] out_bucket_q;
  logic [BKW+chte_pkg::BUCKET_W-1:0] bkt_ext;

  logic in_xfer;
  logic fin_take;

  assign in_stall_o = (state_q != chte_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fin_take   = (state_q == chte_pkg::S_FINISH) && (!out_valid_q || !out_stall_i);

  // bucket index, worked out by the modulo unit as a registered multiply then a registered subtract
  chte_mod #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .key_i   (key_i),
    .done_o  (mod_done),
    .rem_o   (bkt_w)
  );

  chte_store #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (st_ctrl),
    .addr_i (addr_w),
    .bkt_i  (bkt_w),
    .slot_i (slot_q),
    .wkey_i (key_q),
    .rkey_o (rkey_w),
    .row_o  (row_w)
  );

  // slot address within the flat key memory
  assign addr_w = base_q + AW'(slot_q);

  // lowest free slot of the current bucket
  always_comb begin
    any_free  = 1'b0;
    free_slot = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (!row_w[i]) begin
        any_free  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  // one shared key compare, a valid slot only
  assign hit_w  = row_w[slot_q] && (rkey_w == key_q);
  assign last_w = (slot_q == SW'(SLOTS_PER_BUCKET - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chte_pkg::S_IDLE: begin
        if (in_xfer) state_d = chte_pkg::S_MOD;
      end
      chte_pkg::S_MOD: begin
        if (mod_done) state_d = chte_pkg::S_ROW;
      end
      chte_pkg::S_ROW: begin
        priority if (cmd_q == chte_pkg::CMD_INSERT) begin
          state_d = chte_pkg::S_INS;
        end else if (cmd_q == chte_pkg::CMD_SEARCH || cmd_q == chte_pkg::CMD_DELETE) begin
          state_d = chte_pkg::S_READ;
        end else begin
          // unknown command: nothing to do, answer not found
          state_d = chte_pkg::S_FINISH;
        end
      end
      chte_pkg::S_INS:  state_d = chte_pkg::S_FINISH;
      chte_pkg::S_READ: state_d = chte_pkg::S_CMP;
      chte_pkg::S_CMP: begin
        if (hit_w || last_w) state_d = chte_pkg::S_FINISH;
        else                 state_d = chte_pkg::S_READ;
      end
      chte_pkg::S_FINISH: begin
        if (fin_take) state_d = chte_pkg::S_IDLE;
      end
      default: state_d = chte_pkg::S_IDLE;
    endcase
  end

  // store control per state
  always_comb begin
    st_ctrl = '0;
    unique case (state_q)
      chte_pkg::S_INS: begin
        st_ctrl.key_we    = has_free_q;
        st_ctrl.valid_set = has_free_q;
      end
      chte_pkg::S_READ: begin
        st_ctrl.key_re = 1'b1;
      end
      chte_pkg::S_CMP: begin
        // delete drops the first matching copy only
        st_ctrl.valid_clr = hit_w && (cmd_q == chte_pkg::CMD_DELETE);
      end
      default: st_ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
    end
    if (state_q == chte_pkg::S_ROW) begin
      base_q     <= AW'(int'(bkt_w) * SLOTS_PER_BUCKET);
      slot_q     <= (cmd_q == chte_pkg::CMD_INSERT) ? free_slot : '0;
      has_free_q <= any_free;
      status_q   <= chte_pkg::ST_NOT_FOUND;
    end
    if (state_q == chte_pkg::S_INS) begin
      status_q <= has_free_q ? chte_pkg::ST_DONE : chte_pkg::ST_FULL;
    end
    if (state_q == chte_pkg::S_CMP) begin
      if (hit_w) begin
        status_q <= chte_pkg::ST_DONE;
      end else if (!last_w) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // result register
  assign bkt_ext = {{chte_pkg::BUCKET_W{1'b0}}, bkt_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      out_status_q <= status_q;
      out_bucket_q <= bkt_ext[chte_pkg::BUCKET_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign bucket_o    = out_bucket_q;

  `CHTE_ASSERT_NOW(a_slot_range, clk_i, rst_ni, state_q == chte_pkg::S_CMP, int'(slot_q) < SLOTS_PER_BUCKET, "slot counter ran past the bucket")
  `CHTE_ASSERT_NOW(a_bkt_range, clk_i, rst_ni, state_q == chte_pkg::S_ROW, int'(bkt_w) < NUM_BUCKETS, "bucket index out of range")
  `CHTE_ASSERT_NOW(a_set_free, clk_i, rst_ni, st_ctrl.valid_set, !row_w[slot_q], "insert onto an occupied slot")
  `CHTE_ASSERT_NOW(a_clr_del, clk_i, rst_ni, st_ctrl.valid_clr, cmd_q == chte_pkg::CMD_DELETE && row_w[slot_q], "slot cleared outside a delete hit")
  `CHTE_ASSERT_NEXT(a_full_ins, clk_i, rst_ni, fin_take && status_q == chte_pkg::ST_FULL, out_valid_q && cmd_q == chte_pkg::CMD_INSERT, "bucket full reported for a non-insert")

endmodule

### test/chained_hash_table_engine_core_tb.sv
`timescale 1ns / 100ps

module chained_hash_table_engine_core_tb;
  import chte_pkg::*;

  localparam int NB          = NUM_BUCKETS_DEF;
  localparam int SPB         = SLOTS_PER_BUCKET_DEF;
  localparam int RANDOM_REQS = 1450;
  // no idling once the backlog drops below this
  localparam int TAIL_REQS   = 150;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 24;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } table_req_t;

  typedef struct packed {
    status_e             status;
    logic [BUCKET_W-1:0] bucket;
  } table_answer_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i       = '0;
  logic [KEY_W-1:0]    key_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [BUCKET_W-1:0] bucket_o;

  // requests waiting to be driven, and answers waiting to come back
  table_req_t    req_backlog[$];
  table_answer_t table_answers[$];

  // shadow copy of the slot store
  logic [KEY_W-1:0] shadow_key[NB*SPB];
  logic             shadow_used[NB*SPB];

  // inserts issued per bucket; a bucket is only probed once all its slots were written
  int               bucket_inserts[NB];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int   mismatches = 0;
  int   cycles     = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  logic calm       = 1'b0;

  chained_hash_table_engine_core #(
    .NUM_BUCKETS      (NB),
    .SLOTS_PER_BUCKET (SPB)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .bucket_o    (bucket_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // apply one request to the shadow table and work out its answer
  function automatic table_answer_t apply_request(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k);
    table_answer_t ans;
    int unsigned   b;
    int            base;
    int            hit;
    int            hole;
    b    = int'(k) % NB;
    base = b * SPB;
    hit  = -1;
    hole = -1;
    // lowest free slot and lowest matching slot of the bucket
    for (int s = 0; s < SPB; s++) begin
      if (hole < 0 && !shadow_used[base+s]) hole = s;
      if (hit < 0 && shadow_used[base+s] && shadow_key[base+s] == k) hit = s;
    end
    ans.bucket = BUCKET_W'(b);
    ans.status = ST_NOT_FOUND;
    case (op)
      CMD_INSERT: begin
        if (hole < 0) begin
          ans.status = ST_FULL;
        end else begin
          shadow_key[base+hole]  = k;
          shadow_used[base+hole] = 1'b1;
          ans.status             = ST_DONE;
        end
      end
      CMD_SEARCH: begin
        if (hit >= 0) ans.status = ST_DONE;
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          shadow_used[base+hit] = 1'b0;
          ans.status            = ST_DONE;
        end
      end
      default: ; // unused code leaves the table alone
    endcase
    return ans;
  endfunction

  // queue a request; a probe of a bucket not yet fully written becomes an insert
  task automatic queue_request(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k);
    table_req_t  req;
    int unsigned b;
    b = int'(k) % NB;
    if ((op == CMD_SEARCH || op == CMD_DELETE) && bucket_inserts[b] < SPB) op = CMD_INSERT;
    if (op == CMD_INSERT && bucket_inserts[b] < SPB) bucket_inserts[b]++;
    req.cmd = op;
    req.key = k;
    req_backlog.push_back(req);
  endtask

  // stimulus and end of run
  initial begin
    int r;
    int ins_weight;
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] k;

    for (int i = 0; i < NB*SPB; i++) shadow_used[i] = 1'b0;
    for (int i = 0; i < NB; i++) bucket_inserts[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_MAX - 7; // top key of bucket zero
    for (int i = 3; i < POOL_SIZE; i++) begin
      if (i < 12) key_pool[i] = KEY_W'($urandom_range(0, 199));
      else        key_pool[i] = KEY_W'($urandom);
    end

    // directed: fill bucket zero, overflow it, probe and delete, duplicates
    for (int i = 0; i < SPB; i++) queue_request(CMD_INSERT, KEY_W'(i * NB));
    queue_request(CMD_INSERT, KEY_W'(SPB * NB));        // bucket full
    queue_request(CMD_SEARCH, KEY_W'(3 * NB));          // hit in the middle
    queue_request(CMD_SEARCH, KEY_W'((SPB - 1) * NB));  // hit in the last slot
    queue_request(CMD_SEARCH, KEY_W'(90));              // miss
    queue_request(CMD_DELETE, KEY_W'(3 * NB));
    queue_request(CMD_DELETE, KEY_W'(3 * NB));          // already gone
    queue_request(CMD_DELETE, KEY_W'(NB));              // frees slot one
    queue_request(CMD_INSERT, '0);                      // duplicate of key zero
    queue_request(CMD_DELETE, '0);                      // lowest copy removed
    queue_request(CMD_SEARCH, '0);                      // the other copy remains
    queue_request(CMD_DELETE, '0);
    queue_request(CMD_SEARCH, '0);                      // both copies gone
    queue_request(CMD_UNUSED, KEY_MAX);                 // ignored command
    queue_request(CMD_INSERT, KEY_MAX);
    queue_request(CMD_UNUSED, '0);
    queue_request(CMD_INSERT, KEY_MAX - 7);

    // random: pool keys for hits, full-range keys for bit coverage, and keys below 100
    for (int i = 0; i < RANDOM_REQS; i++) begin
      ins_weight = (i < RANDOM_REQS / 3) ? 50 : 28;
      r = $urandom_range(0, 99);
      if (r < 4)                        op = CMD_UNUSED;
      else if (r < 4 + ins_weight)      op = CMD_INSERT;
      else if (r < 52 + ins_weight / 2) op = CMD_SEARCH;
      else                              op = CMD_DELETE;
      r = $urandom_range(0, 99);
      if (r < 55)      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 85) k = KEY_W'($urandom);
      else             k = KEY_W'($urandom_range(0, 99));
      queue_request(op, k);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (table_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && table_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // driver: presents requests, records each transfer in the shadow table
  always @(posedge clk_i or negedge rst_ni) begin : driver
    table_req_t nxt;
    logic       quiet;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= '0;
      key_i      <= '0;
      gap_left   <= 0;
      calm       <= 1'b0;
    end else begin
      quiet = req_backlog.size() < TAIL_REQS;
      if (in_valid_i && !in_stall_o) begin
        table_answers.push_back(apply_request(cmd_i, key_i));
        // switch between bursty and steady stretches now and then
        if ($urandom_range(0, 59) == 0) calm <= ~calm;
      end
      // payload only moves once the current one has been taken
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
          gap_left   <= $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          nxt        = req_backlog.pop_front();
          cmd_i      <= nxt.cmd;
          key_i      <= nxt.key;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives the stall
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    table_answer_t want;
    logic          quiet;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      quiet = req_backlog.size() < TAIL_REQS;
      if (out_valid_o && !out_stall_i) begin
        if (table_answers.size() == 0) begin
          flag_mismatch("result transfer with no answer pending");
        end else begin
          want = table_answers.pop_front();
          if (status_o !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", status_o, want.status));
          if (bucket_o !== want.bucket)
            flag_mismatch($sformatf("bucket %0d, wanted %0d", bucket_o, want.bucket));
        end
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        stall_left  <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
